/* rtl/core/pao_pkg.sv */
// Shared types, constants and the quarter-wave sine table builder for the oscillator.
package pao_pkg;

   // Fixed formats
   localparam int PHASE_BITS  = 32;
   localparam int TABLE_BITS  = 10;
   localparam int SAMPLE_BITS = 16;
   localparam int SAMPLE_RATE = 48000;

   localparam int OFFSET_W = 24;
   localparam int FREQ_W   = 24;
   localparam int MAG_W    = FREQ_W + 1;
   localparam int TABLE_DEPTH = 1 << TABLE_BITS;

   // Frequency scaling: inc = round(mag * 2^(PHASE_BITS-8) / SAMPLE_RATE).
   // SAMPLE_RATE = 2^7 * 375, so the power of two folds into the shift and
   // only the odd factor is divided out, twice, by reciprocal multiply.
   localparam int RATE_POW2   = 7;
   localparam int RATE_ODD    = SAMPLE_RATE / (1 << RATE_POW2);
   localparam int FRAC_SHIFT  = PHASE_BITS - 8 - RATE_POW2;
   localparam int ROUND_BIAS  = (RATE_ODD - 1) / 2;
   localparam int Q_W         = 17;
   localparam int REM_W       = 9;
   localparam int V_W         = 26;
   localparam int RECIP_W     = 27;
   localparam int RECIP_SHIFT = 35;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + 64'(RATE_ODD) - 64'd1) / 64'(RATE_ODD);

   // Configuration register indexes
   localparam logic CSR_WAVE_SELECT   = 1'b0;
   localparam logic CSR_BASE_FREQUENCY = 1'b1;

   localparam logic [FREQ_W-1:0] BASE_FREQ_RESET = 24'd112640;

   // Waveform codes
   localparam logic [1:0] WAVE_SINE   = 2'd0;
   localparam logic [1:0] WAVE_SAW    = 2'd1;
   localparam logic [1:0] WAVE_SQUARE = 2'd2;

   // Load strobes of the increment pipeline
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } incr_ld_type;

   typedef logic [TABLE_DEPTH-1:0][SAMPLE_BITS-1:0] sine_rom_type;

   // Shift-subtract division, only used while building the table
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Quarter-wave table from a Q30 integer Taylor series; run at elaboration.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] s;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         x = (64'd1686629713 * (64'd2 * 64'(k) + 64'd1) + (64'd1 << TABLE_BITS))
             >> (TABLE_BITS + 1);
         term = x;
         sum = x;
         for (int n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = udiv64(term, 64'((2 * n) * (2 * n + 1)));
            if ((n & 1) != 0) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum > 64'd1073741824) begin
            sum = 64'd1073741824;
         end
         s = (sum * (64'd1 << (SAMPLE_BITS - 1)) + (64'd1 << 29)) >> 30;
         if (s > ((64'd1 << (SAMPLE_BITS - 1)) - 64'd1)) begin
            s = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
         end
         rom[k] = s[SAMPLE_BITS-1:0];
      end
      return rom;
   endfunction

endpackage

/* rtl/core/pao_incr.sv */
// Frequency to phase increment: add offset, take magnitude, divide by the sample rate.
module pao_incr
   import pao_pkg::*;
(
   input  logic                       clock,
   input  incr_ld_type                ld,
   input  logic [FREQ_W-1:0]          base_frequency,
   input  logic signed [OFFSET_W-1:0] freq_offset,
   output logic                       inc_neg,
   output logic [PHASE_BITS-1:0]      phase_inc
);

   localparam int PROD1_W = MAG_W + RECIP_W;
   localparam int PROD2_W = V_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

   // Stage 1: total frequency, sign and magnitude
   logic signed [FREQ_W+1:0] freq_sum;
   logic [FREQ_W+1:0]        freq_abs;
   logic                     neg1_in, neg1_ff;
   logic [MAG_W-1:0]         mag1_in, mag1_ff;

   assign freq_sum = $signed({2'b00, base_frequency}) +
                     $signed({{2{freq_offset[OFFSET_W-1]}}, freq_offset});
   assign neg1_in  = freq_sum[FREQ_W+1];
   assign freq_abs = neg1_in ? (FREQ_W+2)'(-freq_sum) : freq_sum;
   assign mag1_in  = freq_abs[MAG_W-1:0];

   // Stage 2: mag * reciprocal of the odd rate factor
   logic                 neg2_ff;
   logic [MAG_W-1:0]     mag2_ff;
   logic [PROD1_W-1:0]   prod1_in, prod1_ff;

   assign prod1_in = PROD1_W'(mag1_ff) * PROD1_W'(RECIP_C);

   // Stage 3: coarse quotient and remainder
   logic [Q_W-1:0]       q3_in, q3_ff;
   logic [MAG_W:0]       q_times_d;
   logic [REM_W-1:0]     r3_in, r3_ff;
   logic                 neg3_ff;

   assign q3_in     = prod1_ff[RECIP_SHIFT +: Q_W];
   assign q_times_d = (MAG_W+1)'(q3_in * RATE_ODD);
   assign r3_in     = REM_W'(mag2_ff - q_times_d[MAG_W-1:0]);

   // Stage 4: rounded fraction of the remainder, shifted up
   logic [V_W-1:0]       v4;
   logic [PROD2_W-1:0]   prod2_in, prod2_ff;
   logic [Q_W-1:0]       q4_ff;
   logic                 neg4_ff;

   assign v4       = {r3_ff, FRAC_SHIFT'(0)} + V_W'(ROUND_BIAS);
   assign prod2_in = PROD2_W'(v4) * PROD2_W'(RECIP_C);

   always_ff @(posedge clock) begin
      if (ld.s1) begin
         neg1_ff <= neg1_in;
         mag1_ff <= mag1_in;
      end
      if (ld.s2) begin
         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         prod1_ff <= prod1_in;
      end
      if (ld.s3) begin
         neg3_ff <= neg2_ff;
         q3_ff   <= q3_in;
         r3_ff   <= r3_in;
      end
      if (ld.s4) begin
         neg4_ff  <= neg3_ff;
         q4_ff    <= q3_ff;
         prod2_ff <= prod2_in;
      end
   end

   // Quotient and fraction never overlap; upper bits wrap away
   assign inc_neg   = neg4_ff;
   assign phase_inc = {q4_ff[PHASE_BITS-FRAC_SHIFT-1:0], prod2_ff[RECIP_SHIFT +: FRAC_SHIFT]};

endmodule

/* rtl/core/pao_wave.sv */
// Waveform shaping from phase: quarter-wave sine, sawtooth and square, registered.
module pao_wave
   import pao_pkg::*;
(
   input  logic                          clock,
   input  logic                          ld_lookup,
   input  logic [PHASE_BITS-1:0]         phase_next,
   input  logic                          ld,
   input  logic [1:0]                    wave_select,
   input  logic [PHASE_BITS-1:0]         phase,
   output logic signed [SAMPLE_BITS-1:0] sample_ff
);

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic [TABLE_BITS-1:0]         idx;
   logic [SAMPLE_BITS-1:0]        sine_mag_ff;
   logic [SAMPLE_BITS-1:0]        sample_in;

   // Quadrant folding into the quarter table, from the phase entering stage 5
   assign idx = phase_next[PHASE_BITS-2] ? ~phase_next[PHASE_BITS-3 -: TABLE_BITS]
                                         : phase_next[PHASE_BITS-3 -: TABLE_BITS];

   // Registered table read, loaded together with the stage 5 phase
   always_ff @(posedge clock) begin
      if (ld_lookup) begin
         sine_mag_ff <= SINE_ROM[idx];
      end
   end

   always_comb begin
      unique case (wave_select)
         WAVE_SINE:   sample_in = phase[PHASE_BITS-1] ? SAMPLE_BITS'(-sine_mag_ff)
                                                      : sine_mag_ff;
         WAVE_SAW:    sample_in = {~phase[PHASE_BITS-1], phase[PHASE_BITS-2 -: SAMPLE_BITS-1]};
         WAVE_SQUARE: sample_in = phase[PHASE_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                                      : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         default:     sample_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         sample_ff <= sample_in;
      end
   end

endmodule

/* rtl/core/phase_accumulator_oscillator_top.sv */
// Throughput: one item per cycle unless rsp_tready stalls the output;
// the only loop is the phase add in stage 5.
// Seven register stages with per-stage valid, so bubbles close up under stall.
// Reset (synchronous, active high) empties the pipeline, clears the phase to
// zero and sets wave_select to sine and base_frequency to 440 Hz.
module phase_accumulator_oscillator_top
   import pao_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // req: freq_offset [23:0]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [OFFSET_W-1:0]    req_tdata,
   // rsp: wave_sample [15:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [SAMPLE_BITS-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [FREQ_W-1:0]      csr_wdata
);

   localparam int NUM_STAGES = 7;

   // Configuration registers
   logic [1:0]        wave_select_ff;
   logic [FREQ_W-1:0] base_freq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_select_ff <= WAVE_SINE;
         base_freq_ff   <= BASE_FREQ_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WAVE_SELECT:    wave_select_ff <= csr_wdata[1:0];
            CSR_BASE_FREQUENCY: base_freq_ff   <= csr_wdata;
            default:            ;
         endcase
      end
   end

   // Per-stage valid and ready; a stage loads when empty or when it drains
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] rdy;

   always_comb begin
      rdy[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[NUM_STAGES-1];

   // Stage 0: input item register
   logic signed [OFFSET_W-1:0] offset_ff;

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         offset_ff <= req_tdata;
      end
   end

   // Stages 1 to 4: phase increment
   incr_ld_type           incr_ld;
   logic                  inc_neg;
   logic [PHASE_BITS-1:0] phase_inc;

   assign incr_ld.s1 = rdy[1];
   assign incr_ld.s2 = rdy[2];
   assign incr_ld.s3 = rdy[3];
   assign incr_ld.s4 = rdy[4];

   pao_incr u_incr (
      .clock          (clock),
      .ld             (incr_ld),
      .base_frequency (base_freq_ff),
      .freq_offset    (offset_ff),
      .inc_neg        (inc_neg),
      .phase_inc      (phase_inc)
   );

   // Stage 5: phase accumulator, advanced once per item
   logic                  phase_step;
   logic [PHASE_BITS-1:0] phase_accum_in, phase_accum_ff;
   logic [PHASE_BITS-1:0] s5_phase_ff;

   assign phase_step     = vld_ff[4] && rdy[5];
   assign phase_accum_in = inc_neg ? phase_accum_ff - phase_inc
                                   : phase_accum_ff + phase_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_accum_ff <= '0;
      end else if (phase_step) begin
         phase_accum_ff <= phase_accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s5_phase_ff <= phase_accum_in;
      end
   end

   // Stage 5 sine table read, stage 6 waveform and result register
   logic signed [SAMPLE_BITS-1:0] sample_ff;

   pao_wave u_wave (
      .clock       (clock),
      .ld_lookup   (rdy[5]),
      .phase_next  (phase_accum_in),
      .ld          (rdy[6]),
      .wave_select (wave_select_ff),
      .phase       (s5_phase_ff),
      .sample_ff   (sample_ff)
   );

   assign rsp_tdata = sample_ff;

   // Checks
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !phase_step |=> phase_accum_ff == $past(phase_accum_ff))
      else $error("phase moved without an item");

   a_phase_copy: assert property (@(posedge clock) disable iff (reset)
      phase_step |=> s5_phase_ff == phase_accum_ff)
      else $error("stage 5 phase differs from accumulator");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      vld_ff == '0 |-> req_tready)
      else $error("empty pipeline not ready");

   a_square_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && wave_select_ff == WAVE_SQUARE |->
         rsp_tdata == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
         rsp_tdata == {1'b1, {(SAMPLE_BITS-1){1'b0}}})
      else $error("square output not at full scale");

endmodule

/* dv/phase_accumulator_oscillator_top_tb.sv */
// Self-checking testbench for the phase accumulator oscillator: steered and random offsets.
`timescale 1ns / 100ps

module phase_accumulator_oscillator_top_tb;
   import pao_pkg::*;

   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 12;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [1:0] WAVE_UNUSED = 2'd3;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   // opening offsets: reset defaults, both extremes, negative and zero frequency
   localparam logic [OFFSET_W-1:0] FIRST_OFFSETS [6] = '{
      24'h000000, 24'h7FFFFF, 24'h800000,
      OFFSET_W'(-int'(BASE_FREQ_RESET)), 24'hFFFFFF, 24'h000001};
   // sine: first and last table entry of every quadrant
   localparam logic [PHASE_BITS-1:0] SINE_MARKS [8] = '{
      32'h0008_0000, 32'h3FF8_0000, 32'h4008_0000, 32'h7FF8_0000,
      32'h8008_0000, 32'hBFF8_0000, 32'hC008_0000, 32'hFFF8_0000};
   // saw and square: both ends of the cycle and both sides of one half
   localparam logic [PHASE_BITS-1:0] EDGE_MARKS [4] = '{
      32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_8000, 32'h8000_8000};
   localparam logic [1:0] PHASE_WAVES [8] = '{
      WAVE_SINE, WAVE_SAW, WAVE_SQUARE, WAVE_SQUARE,
      WAVE_SAW, WAVE_SINE, WAVE_UNUSED, WAVE_SINE};

   // Expected sample queue with its own oscillator state
   class osc_scoreboard;
      logic [1:0]             wave;
      logic [FREQ_W-1:0]      base;
      logic [PHASE_BITS-1:0]  phase;
      logic [SAMPLE_BITS-1:0] quarter_sine [TABLE_DEPTH];
      logic [SAMPLE_BITS-1:0] expected_samples [$];
      int errors;
      int offsets_taken;
      int samples_checked;
      int backward_steps;
      int by_wave [4];

      function new();
         longint unsigned ang;
         longint unsigned term;
         longint unsigned acc;
         longint unsigned steps;
         wave = WAVE_SINE;
         base = BASE_FREQ_RESET;
         phase = '0;
         errors = 0;
         offsets_taken = 0;
         samples_checked = 0;
         backward_steps = 0;
         by_wave = '{0, 0, 0, 0};
         // quarter-wave table, Q30 Taylor series at the center of each bin
         steps = 64'd1 << (TABLE_BITS + 1);
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            ang = (PI_HALF_Q30 * 64'(2 * k + 1) + steps / 2) / steps;
            term = ang;
            acc = ang;
            for (int n = 1; n <= 10; n++) begin
               term = (term * ang) >> 30;
               term = (term * ang) >> 30;
               term = term / 64'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  acc = acc - term;
               end else begin
                  acc = acc + term;
               end
            end
            if (acc > Q30_ONE) acc = Q30_ONE;
            acc = (acc * (64'd1 << (SAMPLE_BITS - 1)) + (64'd1 << 29)) >> 30;
            quarter_sine[k] = (acc > 64'(FULL_SCALE)) ? FULL_SCALE : SAMPLE_BITS'(acc);
         end
      endfunction

      function void set_register(logic idx, logic [FREQ_W-1:0] data);
         if (idx == CSR_WAVE_SELECT) begin
            wave = data[1:0];
         end else begin
            base = data;
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      function logic [SAMPLE_BITS-1:0] sample_at(logic [PHASE_BITS-1:0] ph);
         logic [TABLE_BITS+1:0] top;
         logic [TABLE_BITS-1:0] idx;
         logic [SAMPLE_BITS-1:0] mag;
         case (wave)
            WAVE_SINE: begin
               top = ph[PHASE_BITS-1 -: TABLE_BITS + 2];
               // odd quadrants read the table mirrored, upper half is negated
               idx = top[TABLE_BITS] ? ~top[TABLE_BITS-1:0] : top[TABLE_BITS-1:0];
               mag = quarter_sine[idx];
               return top[TABLE_BITS+1] ? -mag : mag;
            end
            WAVE_SAW: begin
               return {~ph[PHASE_BITS-1], ph[PHASE_BITS-2 -: SAMPLE_BITS - 1]};
            end
            WAVE_SQUARE: begin
               return ph[PHASE_BITS-1] ? ~FULL_SCALE : FULL_SCALE;
            end
            default: begin
               return '0;
            end
         endcase
      endfunction

      // Advance the phase by one item and queue the sample it gives
      function void accept_offset(logic [OFFSET_W-1:0] off);
         longint freq;
         longint unsigned mag;
         logic [PHASE_BITS-1:0] step;
         freq = longint'(base) + longint'($signed(off));
         mag = (freq < 0) ? -freq : freq;
         step = PHASE_BITS'(((mag << (PHASE_BITS - 8)) + SAMPLE_RATE / 2) / SAMPLE_RATE);
         if (freq < 0) begin
            phase = phase - step;
            backward_steps++;
         end else begin
            phase = phase + step;
         end
         by_wave[wave]++;
         offsets_taken++;
         expected_samples.push_back(sample_at(phase));
      endfunction

      function void check_sample(logic [SAMPLE_BITS-1:0] got);
         logic [SAMPLE_BITS-1:0] want;
         if (expected_samples.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("ERROR: sample %0d arrived with no item outstanding", $signed(got));
         end else begin
            want = expected_samples.pop_front();
            samples_checked++;
            if (got !== want) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("ERROR: sample %0d: expected %0d, got %0d",
                           samples_checked, $signed(want), $signed(got));
            end
         end
      endfunction

      // Offset that lands the next phase near the target, at the current base
      function logic [OFFSET_W-1:0] offset_toward(logic [PHASE_BITS-1:0] target);
         logic [PHASE_BITS-1:0] ahead;
         logic [PHASE_BITS-1:0] behind;
         longint freq;
         ahead = target - phase;
         behind = phase - target;
         if (!ahead[PHASE_BITS-1]) begin
            freq = longint'((64'(ahead) * SAMPLE_RATE + (64'd1 << (PHASE_BITS - 9)))
                            >> (PHASE_BITS - 8));
         end else begin
            freq = -longint'((64'(behind) * SAMPLE_RATE + (64'd1 << (PHASE_BITS - 9)))
                             >> (PHASE_BITS - 8));
         end
         return OFFSET_W'(freq - longint'(base));
      endfunction

      function void close_out();
         if (expected_samples.size() != 0) begin
            errors += expected_samples.size();
            $display("ERROR: %0d samples never arrived", expected_samples.size());
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [OFFSET_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic csr_index = CSR_WAVE_SELECT;
   logic [FREQ_W-1:0] csr_wdata = '0;

   osc_scoreboard sb;
   bit tight_send = 1'b0;
   bit rsp_hold_req = 1'b0;
   int settings = 0;
   int stuck_cycles = 0;

   phase_accumulator_oscillator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Monitor both channels and watch for a stuck run
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.accept_offset(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_sample(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
            if (stuck_cycles >= IDLE_LIMIT) begin
               $display("ERROR: no item moved for %0d cycles", IDLE_LIMIT);
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
      end
   end

   // Receiver: ready runs broken by short and long stalls, plus one long hold-off
   initial begin : rsp_side
      int run_left;
      int stall_left;
      int hold_left;
      run_left = 0;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            hold_left = RSP_HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_tready <= 1'b1;
         end else begin
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: stall_left = 0;
               9: stall_left = $urandom_range(8, 40);
               default: stall_left = $urandom_range(1, 3);
            endcase
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 17) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [OFFSET_W-1:0] rand_offset();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) return OFFSET_W'($urandom_range(0, 4096)) - OFFSET_W'(2048);
      if (pick == 2) return OFFSET_W'(24'h7FFFFF - $urandom_range(0, 15));
      if (pick == 3) return OFFSET_W'(24'h800000 + $urandom_range(0, 15));
      return OFFSET_W'($urandom);
   endfunction

   // wave code in the low bits, junk above it that the register drops
   function automatic logic [FREQ_W-1:0] wave_word(logic [1:0] code);
      return {(FREQ_W-2)'($urandom), code};
   endfunction

   // All tasks start and end at a falling edge
   task automatic send_offset(input logic [OFFSET_W-1:0] off);
      int gap;
      gap = tight_send ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= off;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   task automatic send_toward(input logic [PHASE_BITS-1:0] target);
      send_offset(sb.offset_toward(target));
   endtask

   // Stop offering items and wait until every sample is back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [FREQ_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_register(idx, data);
      settings++;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [FREQ_W-1:0] fbase;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, offset extremes, steered table corners, then saw, square and unused wave codes
      foreach (FIRST_OFFSETS[i]) send_offset(FIRST_OFFSETS[i]);
      foreach (SINE_MARKS[i]) send_toward(SINE_MARKS[i]);
      settle();
      write_reg(CSR_WAVE_SELECT, wave_word(WAVE_SAW));
      foreach (EDGE_MARKS[i]) send_toward(EDGE_MARKS[i]);
      settle();
      write_reg(CSR_WAVE_SELECT, wave_word(WAVE_SQUARE));
      foreach (EDGE_MARKS[i]) send_toward(EDGE_MARKS[i]);
      settle();
      write_reg(CSR_WAVE_SELECT, wave_word(WAVE_UNUSED));
      send_offset('0);
      send_offset(24'h7FFFFF);

      // random offsets over a series of register settings
      for (int p = 0; p < 8; p++) begin
         settle();
         write_reg(CSR_WAVE_SELECT, wave_word(PHASE_WAVES[p]));
         case (p % 4)
            0: fbase = FREQ_W'($urandom);
            1: fbase = '1;
            2: fbase = '0;
            default: fbase = BASE_FREQ_RESET;
         endcase
         write_reg(CSR_BASE_FREQUENCY, fbase);
         // back-pressure: receiver holds off while the sender keeps pushing
         if (p == 3) begin
            tight_send = 1'b1;
            rsp_hold_req = 1'b1;
         end
         for (int i = 0; i < ((PHASE_WAVES[p] == WAVE_UNUSED) ? 20 : 65); i++)
            send_offset(rand_offset());
         tight_send = 1'b0;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.close_out();
      $display("Run: %0d offsets, %0d samples checked, %0d register writes, %0d backward steps",
               sb.offsets_taken, sb.samples_checked, settings, sb.backward_steps);
      $display("Per waveform: sine %0d, saw %0d, square %0d, unused code %0d",
               sb.by_wave[WAVE_SINE], sb.by_wave[WAVE_SAW], sb.by_wave[WAVE_SQUARE],
               sb.by_wave[WAVE_UNUSED]);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/pao_pkg.sv
rtl/core/pao_incr.sv
rtl/core/pao_wave.sv
rtl/core/phase_accumulator_oscillator_top.sv
dv/phase_accumulator_oscillator_top_tb.sv
